// ===== rtl/core/eyrm_pkg.sv =====
// package: types, constants and arithmetic helpers for the euler to rotation matrix block
package eyrm_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ANG_W = 18;
	localparam int ELEM_W = 16;
	localparam int VAL_W = 33;

	localparam logic signed [ANG_W:0] ANG_FULL = 19'sd92160;
	localparam logic signed [ANG_W:0] ANG_HALF = 19'sd46080;
	localparam logic signed [ANG_W:0] ANG_QUARTER = 19'sd23040;
	localparam logic signed [VAL_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	typedef logic signed [ANG_W-1:0] angle_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		val_t x;
		val_t y;
		val_t z;
		logic flip;
	} cordic_t;

	function automatic val_t atan_q24(input int i);
		case (i)
			0: return 33'sd754974720;
			1: return 33'sd445687602;
			2: return 33'sd235489088;
			3: return 33'sd119537938;
			4: return 33'sd60000934;
			5: return 33'sd30029717;
			6: return 33'sd15018523;
			7: return 33'sd7509720;
			8: return 33'sd3754917;
			9: return 33'sd1877466;
			10: return 33'sd938734;
			11: return 33'sd469367;
			12: return 33'sd234684;
			13: return 33'sd117342;
			14: return 33'sd58671;
			15: return 33'sd29335;
			16: return 33'sd14668;
			17: return 33'sd7334;
			18: return 33'sd3667;
			19: return 33'sd1833;
			20: return 33'sd917;
			21: return 33'sd458;
			22: return 33'sd229;
			23: return 33'sd115;
			default: return 33'sd0;
		endcase
	endfunction

	function automatic val_t mul_q30(input val_t a, input val_t b);
		logic signed [2*VAL_W-1:0] p;
		logic signed [2*VAL_W-1:0] r;
		p = 66'(a) * 66'(b);
		r = (p + (66'sd1 <<< 29)) >>> 30;
		return r[VAL_W-1:0];
	endfunction

	function automatic elem_t to_q15(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W+1:0] r;
		r = (v + 35'sd16384) >>> 15;
		if (r > 35'sd32767)
			return 16'sh7fff;
		else if (r < -35'sd32768)
			return 16'sh8000;
		else
			return r[ELEM_W-1:0];
	endfunction

endpackage

// ===== rtl/core/eyrm_in_if.sv =====
// interface: input channel carrying yaw, pitch and roll angles
interface eyrm_in_if
	import eyrm_pkg::*;
;
	logic valid;
	logic ready;
	angle_t yaw_angle;
	angle_t pitch_angle;
	angle_t roll_angle;

	modport source(output valid, yaw_angle, pitch_angle, roll_angle, input ready);
	modport sink(input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

// ===== rtl/core/eyrm_out_if.sv =====
// interface: output channel carrying the nine rotation matrix elements
interface eyrm_out_if
	import eyrm_pkg::*;
;
	logic valid;
	logic ready;
	elem_t m_row0_col0;
	elem_t m_row1_col0;
	elem_t m_row2_col0;
	elem_t m_row0_col1;
	elem_t m_row1_col1;
	elem_t m_row2_col1;
	elem_t m_row0_col2;
	elem_t m_row1_col2;
	elem_t m_row2_col2;

	modport source(output valid, m_row0_col0, m_row1_col0, m_row2_col0, m_row0_col1,
		m_row1_col1, m_row2_col1, m_row0_col2, m_row1_col2, m_row2_col2, input ready);
	modport sink(input valid, m_row0_col0, m_row1_col0, m_row2_col0, m_row0_col1,
		m_row1_col1, m_row2_col1, m_row0_col2, m_row1_col2, m_row2_col2, output ready);
endinterface

// ===== rtl/core/euler_ypr_to_rotation_matrix.sv =====
// top level: yaw, pitch, roll angles to 3x3 rotation matrix
//
//   channel  dir  payload
//   pose     in   yaw_angle, pitch_angle, roll_angle (18 bit, 1/256 degree)
//   matrix   out  m_row0_col0 .. m_row2_col2 (16 bit q1.15)
//
// one item per cycle while matrix.ready is high or the output holds no valid matrix;
// the pipeline is the cordic cell row plus three product and rounding stages
// reset clears only the valid bits of the pipeline
// a stalled output freezes the whole pipeline; pose.ready is high while matrix.ready is high or matrix.valid is low
module euler_ypr_to_rotation_matrix
	import eyrm_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
	input logic clk,
	input logic arst_n,
	eyrm_in_if.sink pose,
	eyrm_out_if.source matrix
);
	localparam int N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	logic en;
	logic [N-1:0] vld_q;
	cordic_t ch_y [N+1];
	cordic_t ch_p [N+1];
	cordic_t ch_r [N+1];
	val_t cy, sy, cp, sp, cr, sr;
	elem_t m [9];
	logic m_valid;

	assign en = !m_valid || matrix.ready;
	assign pose.ready = en;

	eyrm_reduce u_red_y (.angle(pose.yaw_angle), .seed(ch_y[0]));
	eyrm_reduce u_red_p (.angle(pose.pitch_angle), .seed(ch_p[0]));
	eyrm_reduce u_red_r (.angle(pose.roll_angle), .seed(ch_r[0]));

	for (genvar i = 0; i < N; i++) begin : g_cell
		eyrm_cordic_cell #(.STAGE(i)) u_cy (.clk(clk), .en(en), .d(ch_y[i]), .q_s(ch_y[i+1]));
		eyrm_cordic_cell #(.STAGE(i)) u_cp (.clk(clk), .en(en), .d(ch_p[i]), .q_s(ch_p[i+1]));
		eyrm_cordic_cell #(.STAGE(i)) u_cr (.clk(clk), .en(en), .d(ch_r[i]), .q_s(ch_r[i+1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[N-2:0], pose.valid};
	end

	assign cy = ch_y[N].flip ? -ch_y[N].x : ch_y[N].x;
	assign sy = ch_y[N].flip ? -ch_y[N].y : ch_y[N].y;
	assign cp = ch_p[N].flip ? -ch_p[N].x : ch_p[N].x;
	assign sp = ch_p[N].flip ? -ch_p[N].y : ch_p[N].y;
	assign cr = ch_r[N].flip ? -ch_r[N].x : ch_r[N].x;
	assign sr = ch_r[N].flip ? -ch_r[N].y : ch_r[N].y;

	eyrm_matrix u_mat (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(vld_q[N-1]),
		.cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr),
		.valid_s3(m_valid), .m_s3(m)
	);

	assign matrix.valid = m_valid;
	assign matrix.m_row0_col0 = m[0];
	assign matrix.m_row1_col0 = m[1];
	assign matrix.m_row2_col0 = m[2];
	assign matrix.m_row0_col1 = m[3];
	assign matrix.m_row1_col1 = m[4];
	assign matrix.m_row2_col1 = m[5];
	assign matrix.m_row0_col2 = m[6];
	assign matrix.m_row1_col2 = m[7];
	assign matrix.m_row2_col2 = m[8];
endmodule

// ===== rtl/core/eyrm_reduce.sv =====
// angle reduction modulo 360 degrees, fold into +-90 degrees, cordic seed
module eyrm_reduce
	import eyrm_pkg::*;
(
	input  angle_t  angle,
	output cordic_t seed
);
	logic signed [ANG_W:0] a_w;
	logic signed [ANG_W:0] a_f;
	logic flip;

	always_comb begin
		a_w = {angle[ANG_W-1], angle};
		if (a_w >= ANG_HALF)
			a_w = a_w - ANG_FULL;
		else if (a_w < -ANG_HALF)
			a_w = a_w + ANG_FULL;
		flip = 1'b0;
		a_f = a_w;
		if (a_w > ANG_QUARTER) begin
			a_f = a_w - ANG_HALF;
			flip = 1'b1;
		end else if (a_w < -ANG_QUARTER) begin
			a_f = a_w + ANG_HALF;
			flip = 1'b1;
		end
	end

	assign seed.x = CORDIC_GAIN_Q30;
	assign seed.y = '0;
	assign seed.z = VAL_W'(a_f) <<< 16;
	assign seed.flip = flip;
endmodule

// ===== rtl/core/eyrm_cordic_cell.sv =====
// one cordic rotation cell, registered, fixed shift and arctangent per position
module eyrm_cordic_cell
	import eyrm_pkg::*;
#(
	parameter int STAGE = 0
)(
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q_s
);
	localparam val_t ATAN = atan_q24(STAGE);
	val_t dx, dy;
	cordic_t nxt;

	always_comb begin
		dx = d.x >>> STAGE;
		dy = d.y >>> STAGE;
		nxt.flip = d.flip;
		if (d.z >= 0) begin
			nxt.x = d.x - dy;
			nxt.y = d.y + dx;
			nxt.z = d.z - ATAN;
		end else begin
			nxt.x = d.x + dy;
			nxt.y = d.y - dx;
			nxt.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q_s <= nxt;
	end
endmodule

// ===== rtl/core/eyrm_matrix.sv =====
// product pipeline forming the nine matrix elements from sines and cosines
module eyrm_matrix
	import eyrm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  val_t  cy, sy, cp, sp, cr, sr,
	output logic  valid_s3,
	output elem_t m_s3 [9]
);
	logic valid_s1, valid_s2;
	val_t cycp_s1, sycp_s1, cysp_s1, sysp_s1, sycr_s1, cycr_s1, cpsr_s1, sysr_s1;
	val_t cysr_s1, cpcr_s1, sp_s1, sr_s1, cr_s1;
	val_t cycp_s2, sycp_s2, sycr_s2, cycr_s2, cpsr_s2, sysr_s2, cysr_s2, cpcr_s2, sp_s2;
	val_t t01_s2, t11_s2, t02_s2, t12_s2;

	function automatic logic signed [VAL_W+1:0] ext(input val_t v);
		return {{2{v[VAL_W-1]}}, v};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycp_s1 <= mul_q30(cy, cp);
			sycp_s1 <= mul_q30(sy, cp);
			cysp_s1 <= mul_q30(cy, sp);
			sysp_s1 <= mul_q30(sy, sp);
			sycr_s1 <= mul_q30(sy, cr);
			cycr_s1 <= mul_q30(cy, cr);
			cpsr_s1 <= mul_q30(cp, sr);
			sysr_s1 <= mul_q30(sy, sr);
			cysr_s1 <= mul_q30(cy, sr);
			cpcr_s1 <= mul_q30(cp, cr);
			sp_s1 <= sp;
			sr_s1 <= sr;
			cr_s1 <= cr;

			t01_s2 <= mul_q30(cysp_s1, sr_s1);
			t11_s2 <= mul_q30(sysp_s1, sr_s1);
			t02_s2 <= mul_q30(cysp_s1, cr_s1);
			t12_s2 <= mul_q30(sysp_s1, cr_s1);
			cycp_s2 <= cycp_s1;
			sycp_s2 <= sycp_s1;
			sycr_s2 <= sycr_s1;
			cycr_s2 <= cycr_s1;
			cpsr_s2 <= cpsr_s1;
			sysr_s2 <= sysr_s1;
			cysr_s2 <= cysr_s1;
			cpcr_s2 <= cpcr_s1;
			sp_s2 <= sp_s1;

			m_s3[0] <= to_q15(ext(cycp_s2));
			m_s3[1] <= to_q15(ext(sycp_s2));
			m_s3[2] <= to_q15(-ext(sp_s2));
			m_s3[3] <= to_q15(ext(t01_s2) - ext(sycr_s2));
			m_s3[4] <= to_q15(ext(t11_s2) + ext(cycr_s2));
			m_s3[5] <= to_q15(ext(cpsr_s2));
			m_s3[6] <= to_q15(ext(t02_s2) + ext(sysr_s2));
			m_s3[7] <= to_q15(ext(t12_s2) - ext(cysr_s2));
			m_s3[8] <= to_q15(ext(cpcr_s2));
		end
	end
endmodule

// ===== tb/sv/euler_ypr_to_rotation_matrix_tb.sv =====
// testbench: random and directed poses checked against a bit-exact matrix predictor
`timescale 1ns / 100ps

module euler_ypr_to_rotation_matrix_tb;
	import eyrm_pkg::*;

	localparam int N_RANDOM = 830;
	localparam int LATENCY = CORDIC_STAGES_DEF + 3;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		elem_t e[9];
	} matrix_t;

	class matrix_scoreboard;
		matrix_t pending[$];
		int n_poses;
		int n_matrices;
		int n_errors;

		function automatic longint asr64(longint v, int s);
			return v >>> s;
		endfunction

		function automatic longint qmul(longint a, longint b);
			return (a * b + (64'sd1 <<< 29)) >>> 30;
		endfunction

		function automatic elem_t q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return elem_t'(r);
		endfunction

		function automatic void sincos(angle_t ang, output longint s, output longint c);
			longint a;
			longint x;
			longint y;
			longint z;
			longint nx;
			bit flip;
			a = longint'(ang) % 92160;
			flip = 1'b0;
			if (a < 0)
				a += 92160;
			if (a >= 46080)
				a -= 92160;
			if (a > 23040) begin
				a -= 46080;
				flip = 1'b1;
			end else if (a < -23040) begin
				a += 46080;
				flip = 1'b1;
			end
			z = a * 65536;
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
				if (z >= 0) begin
					nx = x - asr64(y, i);
					y = y + asr64(x, i);
					z -= longint'(atan_q24(i));
				end else begin
					nx = x + asr64(y, i);
					y = y - asr64(x, i);
					z += longint'(atan_q24(i));
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_pose(angle_t yaw, angle_t pitch, angle_t roll);
			longint sy, cy, sp, cp, sr, cr, cysp, sysp;
			matrix_t m;
			sincos(yaw, sy, cy);
			sincos(pitch, sp, cp);
			sincos(roll, sr, cr);
			cysp = qmul(cy, sp);
			sysp = qmul(sy, sp);
			m.e[0] = q15(qmul(cy, cp));
			m.e[1] = q15(qmul(sy, cp));
			m.e[2] = q15(-sp);
			m.e[3] = q15(qmul(cysp, sr) - qmul(sy, cr));
			m.e[4] = q15(qmul(sysp, sr) + qmul(cy, cr));
			m.e[5] = q15(qmul(cp, sr));
			m.e[6] = q15(qmul(cysp, cr) + qmul(sy, sr));
			m.e[7] = q15(qmul(sysp, cr) - qmul(cy, sr));
			m.e[8] = q15(qmul(cp, cr));
			pending.insert(pending.size(), m);
			n_poses++;
		endfunction

		function void check_matrix(matrix_t got);
			matrix_t want;
			n_matrices++;
			if (pending.size() == 0) begin
				$display("%0t: matrix with none expected, got %p", $time, got.e);
				n_errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (want.e[k] !== got.e[k]) begin
					$display("%0t: element %0d expected %0d actual %0d", $time, k,
						want.e[k], got.e[k]);
					n_errors++;
				end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	eyrm_in_if pose();
	eyrm_out_if matrix();
	matrix_scoreboard sb;
	longint cycles;
	bit sending_done;

	euler_ypr_to_rotation_matrix dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose.sink),
		.matrix(matrix.source)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic angle_t rand_angle();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return angle_t'(23040 * $urandom_range(0, 11) - 131072 + 131072 % 1);
			1: return angle_t'(($urandom_range(0, 7) - 4) * 23040 + $urandom_range(0, 4) - 2);
			default: return angle_t'($urandom());
		endcase
	endfunction

	task automatic send_pose(angle_t y, angle_t p, angle_t r);
		int gap;
		pose.valid <= 1'b1;
		pose.yaw_angle <= y;
		pose.pitch_angle <= p;
		pose.roll_angle <= r;
		do
			@(posedge clk);
		while (!pose.ready);
		sb.note_pose(y, p, r);
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			pose.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		pose.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		angle_t dir_vals[$];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		pose.valid = 1'b0;
		pose.yaw_angle = '0;
		pose.pitch_angle = '0;
		pose.roll_angle = '0;
		matrix.ready = 1'b0;
		sending_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// extremes, quarter and half turns, fold boundaries, wrap at 360
		dir_vals = '{18'sh1ffff, -18'sh20000, 18'sd0, 18'sd23040, -18'sd23040, 18'sd23041,
			-18'sd23041, 18'sd46080, -18'sd46080, 18'sd92160, -18'sd92160, 18'sd256,
			-18'sd256, 18'sd69120, 18'sd1};
		foreach (dir_vals[i])
			send_pose(dir_vals[i], dir_vals[(i + 3) % dir_vals.size()],
				dir_vals[(i + 7) % dir_vals.size()]);
		send_pose(18'sd0, 18'sd0, 18'sd0);
		send_pose(18'sd0, 18'sd23040, 18'sd0);
		send_pose(18'sd0, -18'sd23040, 18'sd23040);
		send_pose(18'sd23040, 18'sd23040, 18'sd23040);
		send_pose(18'sd46080, 18'sd0, 18'sd46080);
		drain();
		for (int i = 0; i < N_RANDOM; i++) begin
			send_pose(rand_angle(), rand_angle(), rand_angle());
			if (i == N_RANDOM / 2)
				drain();
		end
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		sending_done = 1'b1;
	end

	// output side stalls, with stretches of steady acceptance
	initial begin
		int steady;
		steady = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady > 0) begin
				matrix.ready <= 1'b1;
				steady--;
			end else if ($urandom_range(0, 49) == 0) begin
				steady = $urandom_range(20, 80);
				matrix.ready <= 1'b1;
			end else
				matrix.ready <= (gap_len() == 0);
		end
	end

	always @(posedge clk) begin
		matrix_t got;
		if (arst_n && matrix.valid && matrix.ready) begin
			got.e[0] = matrix.m_row0_col0;
			got.e[1] = matrix.m_row1_col0;
			got.e[2] = matrix.m_row2_col0;
			got.e[3] = matrix.m_row0_col1;
			got.e[4] = matrix.m_row1_col1;
			got.e[5] = matrix.m_row2_col1;
			got.e[6] = matrix.m_row0_col2;
			got.e[7] = matrix.m_row1_col2;
			got.e[8] = matrix.m_row2_col2;
			sb.check_matrix(got);
		end
	end

	initial begin
		cycles = 0;
		while (!sending_done && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (!sending_done) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
		end else begin
			$display("%0d poses sent, %0d matrices checked, angles over the full field range",
				sb.n_poses, sb.n_matrices);
			if (sb.n_errors == 0 && sb.pending.size() == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
		end
		$finish;
	end

endmodule
